[design/fbm_pkg.sv]
// Shared types and constants for the first-occurrence byte matcher.
// No dependencies; imported by every module of the block.
package fbm_pkg;

  localparam int BYTE_W         = 8;
  localparam int MATCH_OFFSET_W = 32;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  // One processed word, as seen by the pattern and window units.
  typedef struct packed {
    logic pat_step;
    logic text_step;
    logic last;
  } step_t;

endpackage

[design/fbm_pattern.sv]
// Pattern store: shift register of loaded bytes (newest at lane 0), length and overflow.
// Depends on fbm_pkg.
module fbm_pattern
  import fbm_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_W       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  step_t             step,
  input  logic [BYTE_W-1:0] data_byte,
  output logic [BYTE_W-1:0] pat [PATTERN_MAX],
  output logic [LEN_W-1:0]  pat_len,
  output logic              overflow
);

  logic             closed;
  logic             start;
  logic [LEN_W-1:0] len_base;
  logic             ovf_base;
  logic             room;

  always_comb begin
    start    = step.pat_step && closed;
    len_base = start ? '0 : pat_len;
    ovf_base = start ? 1'b0 : overflow;
    room     = len_base < LEN_W'(PATTERN_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closed   <= 1'b1;
      pat_len  <= '0;
      overflow <= 1'b0;
    end else if (step.pat_step) begin
      closed   <= step.last;
      pat_len  <= room ? len_base + LEN_W'(1) : len_base;
      overflow <= ovf_base | ~room;
    end else if (step.text_step) begin
      closed <= 1'b1;
    end
  end

  // Lane i holds pattern byte (len-1-i), so it lines up with window lane i.
  always_ff @(posedge clk) begin
    if (step.pat_step && room) begin
      pat[0] <= data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
        pat[i] <= pat[i-1];
      end
    end
  end

endmodule

[design/fbm_window.sv]
// Text window, stream count and parallel compare against the pattern lanes.
// Depends on fbm_pkg; fed by fbm_pattern.
module fbm_window
  import fbm_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 32,
  parameter int LEN_W       = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  step_t                     step,
  input  logic [BYTE_W-1:0]         data_byte,
  input  logic [BYTE_W-1:0]         pat [PATTERN_MAX],
  input  logic [LEN_W-1:0]          pat_len,
  input  logic                      overflow,
  output logic                      give,
  output logic                      hit,
  output logic [MATCH_OFFSET_W-1:0] offset
);

  localparam int CMP_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;

  logic [BYTE_W-1:0]      win      [PATTERN_MAX];
  logic [BYTE_W-1:0]      win_next [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] count;
  logic [OFFSET_BITS-1:0] count_next;
  logic                   answered;
  logic                   active;
  logic [PATTERN_MAX-1:0] lane_ok;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       len_ext;
  logic [CMP_W-1:0]       diff;
  logic                   long_enough;
  logic                   give_raw;
  logic                   hit_raw;

  always_comb begin
    win_next[0] = data_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_next[i] = win[i-1];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      lane_ok[i] = (LEN_W'(i) >= pat_len) || (win_next[i] == pat[i]);
    end
  end

  always_comb begin
    count_next  = (&count) ? count : count + OFFSET_BITS'(1);
    count_ext   = CMP_W'(count_next);
    len_ext     = CMP_W'(pat_len);
    long_enough = count_ext >= len_ext;
    diff        = count_ext - len_ext;
    active      = step.text_step && !answered;

    give_raw = step.last;
    hit_raw  = 1'b0;
    offset   = '0;
    if (overflow) begin
      give_raw = step.last;
    end else if (pat_len == '0) begin
      give_raw = 1'b1;
      hit_raw  = 1'b1;
    end else if (long_enough && (&lane_ok)) begin
      give_raw = 1'b1;
      hit_raw  = 1'b1;
      offset   = MATCH_OFFSET_W'(diff);
    end
    give = active && give_raw;
    hit  = active && hit_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      answered <= 1'b0;
    end else if (step.pat_step) begin
      count    <= '0;
      answered <= 1'b0;
    end else if (step.text_step) begin
      if (answered) begin
        // rest of an answered stream is dropped until its last word
        if (step.last) begin
          count    <= '0;
          answered <= 1'b0;
        end
      end else begin
        count    <= step.last ? '0 : count_next;
        answered <= step.last ? 1'b0 : give_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      win <= win_next;
    end
  end

endmodule

[design/first_occurrence_byte_matcher.sv]
// First-occurrence byte matcher, top level.
// Input channel (item_valid/item_ready): one word per byte. operation 0 loads a
// pattern byte, and last closes the pattern; operation 1 streams a text byte,
// and last ends the text stream. A pattern word after a closed pattern starts a
// new pattern and abandons any open text stream.
// Result channel (result_valid/result_ready): one word per text stream, at the
// first match (found, start offset) or at the stream's last byte if none.
// pattern_overflow is set when the pattern ran past PATTERN_MAX bytes.
// Throughput: one word per cycle while the result receiver keeps up. A word is
// registered at the input, compared across all PATTERN_MAX lanes when it leaves
// that register, and any result it gives is then held in the output register.
// When the receiver stalls, the held result blocks processing of the input
// register; item_ready falls once that register is also full.
// Reset clears the pattern to empty (every stream then matches at offset 0).
module first_occurrence_byte_matcher
  import fbm_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      operation,
  input  logic [BYTE_W-1:0]         data_byte,
  input  logic                      last,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      found,
  output logic [MATCH_OFFSET_W-1:0] match_offset,
  output logic                      pattern_overflow
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                      in_full;
  op_t                       op_r;
  logic [BYTE_W-1:0]         byte_r;
  logic                      last_r;
  logic                      advance;
  step_t                     step;
  logic [BYTE_W-1:0]         pat [PATTERN_MAX];
  logic [LEN_W-1:0]          pat_len;
  logic                      overflow;
  logic                      give;
  logic                      hit;
  logic [MATCH_OFFSET_W-1:0] offset;

  always_comb begin
    advance        = in_full && (!result_valid || result_ready);
    item_ready     = !in_full || advance;
    step.pat_step  = advance && (op_r == OP_PATTERN);
    step.text_step = advance && (op_r == OP_TEXT);
    step.last      = last_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op_r   <= op_t'(operation);
      byte_r <= data_byte;
      last_r <= last;
    end
  end

  fbm_pattern #(
    .PATTERN_MAX(PATTERN_MAX),
    .LEN_W      (LEN_W)
  ) u_pattern (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_byte(byte_r),
    .pat      (pat),
    .pat_len  (pat_len),
    .overflow (overflow)
  );

  fbm_window #(
    .PATTERN_MAX(PATTERN_MAX),
    .OFFSET_BITS(OFFSET_BITS),
    .LEN_W      (LEN_W)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_byte(byte_r),
    .pat      (pat),
    .pat_len  (pat_len),
    .overflow (overflow),
    .give     (give),
    .hit      (hit),
    .offset   (offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= give;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && give) begin
      found            <= hit;
      match_offset     <= offset;
      pattern_overflow <= overflow;
    end
  end

`ifndef SYNTHESIS
  a_hit_no_overflow: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> !pattern_overflow)
    else $error("match reported with an overflowed pattern");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_offset == '0)
    else $error("nonzero offset on a miss");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with an empty result register");

  a_pattern_no_result: assert property (@(posedge clk) disable iff (rst)
    step.pat_step |=> !result_valid)
    else $error("pattern word produced a result");
`endif

endmodule
